// ===== sv/fcpr_pkg.sv =====
// Shared types and constants for the framed command packet receiver.
// No dependencies; imported by framed_command_packet_receiver_top.
package fcpr_pkg;

  // Frame layout and defaults.
  localparam int unsigned FRAME_BYTES       = 8;
  localparam int unsigned GAIN_BITS_DEFAULT = 16;
  localparam logic [7:0]  PREAMBLE_RESET    = 8'hAA;
  localparam logic [7:0]  LENGTH_BYTE       = 8'(FRAME_BYTES);

  // Frame type codes.
  localparam logic [7:0] TYPE_LAST_MODE = 8'd8;
  localparam logic [7:0] TYPE_P_UP      = 8'd9;
  localparam logic [7:0] TYPE_P_DOWN    = 8'd10;
  localparam logic [7:0] TYPE_P1_UP     = 8'd11;
  localparam logic [7:0] TYPE_P1_DOWN   = 8'd12;
  localparam logic [7:0] TYPE_P2_UP     = 8'd13;
  localparam logic [7:0] TYPE_P2_DOWN   = 8'd14;
  localparam logic [7:0] TYPE_MAX       = TYPE_P2_DOWN;

  // Flight modes that grant gain changes.
  localparam logic [3:0] MODE_P_ONLY_A = 4'd4;
  localparam logic [3:0] MODE_ALL_A    = 4'd5;
  localparam logic [3:0] MODE_ALL_B    = 4'd6;
  localparam logic [3:0] MODE_P_ONLY_B = 4'd7;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_BAD_PRE  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_BAD_TYPE = 3'd4,
    ST_BAD_SUM  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [3:0] current_mode;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic              mode_request_valid;
    logic [3:0]        requested_mode;
    logic signed [7:0] roll_cmd;
    logic signed [7:0] pitch_cmd;
    logic signed [7:0] yaw_cmd;
    logic [7:0]        lift_cmd;
    logic [15:0]       gain_p_out;
    logic [15:0]       gain_p1_out;
    logic [15:0]       gain_p2_out;
  } out_t;

endpackage

// ===== sv/framed_command_packet_receiver_top.sv =====
// Framed command packet receiver: frame parser, gain registers, output skid stage.
// Depends on fcpr_pkg for the request types, phase and status codes.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------
//  in      | into      | in_valid/in_stall | in_data  (in_t)
//  out     | out of    | out_valid/out_stall | out_data (out_t)
//  cfg     | into      | cfg_we            | cfg_wdata (preamble byte)
//
// The parser step is combinational from the input and the frame state, and
// its result is registered in the output stage.
// One request is accepted every cycle while the output is being taken.
// A skid register holds one extra result, so in_stall rises only when both
// the output register and the skid register are full.
// Reset (rst, synchronous) restarts the preamble hunt, clears gains, mode and
// setpoints, and sets the preamble byte to 0xAA.
module framed_command_packet_receiver_top
  import fcpr_pkg::*;
#(
  parameter int unsigned GAIN_BITS = GAIN_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Frame state.
  logic [7:0]           preamble;
  phase_t               phase, phase_next;
  logic [2:0]           byte_position, byte_position_next;
  logic [7:0]           running_xor, running_xor_next;
  logic [7:0]           frame_type;
  logic [7:0]           payload [4];
  logic [GAIN_BITS-1:0] gain_p, gain_p_next;
  logic [GAIN_BITS-1:0] gain_p1, gain_p1_next;
  logic [GAIN_BITS-1:0] gain_p2, gain_p2_next;
  logic [3:0]           pending_mode, pending_mode_next;
  logic [7:0]           held [4];
  logic                 held_load;

  // Handshake and output stage.
  logic accept;
  logic out_take;
  logic skid_valid;
  out_t skid;
  out_t result;
  status_t status;
  logic mode_req;
  logic [1:0] payload_index;
  logic [15:0] gain_p_wide, gain_p1_wide, gain_p2_wide;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;
  assign payload_index = byte_position[1:0] - 2'd3;

  // Saturating gain steps.
  function automatic logic [GAIN_BITS-1:0] gain_up(input logic [GAIN_BITS-1:0] g);
    gain_up = (&g) ? g : g + 1'b1;
  endfunction

  function automatic logic [GAIN_BITS-1:0] gain_down(input logic [GAIN_BITS-1:0] g);
    gain_down = (g == '0) ? g : g - 1'b1;
  endfunction

  // Parser step for one request.
  always_comb begin
    logic p_ok;
    logic all_ok;
    p_ok   = (in_data.current_mode == MODE_P_ONLY_A) || (in_data.current_mode == MODE_ALL_A) ||
             (in_data.current_mode == MODE_ALL_B) || (in_data.current_mode == MODE_P_ONLY_B);
    all_ok = (in_data.current_mode == MODE_ALL_A) || (in_data.current_mode == MODE_ALL_B);
    phase_next          = PH_HUNT;
    byte_position_next  = 3'd0;
    running_xor_next    = 8'd0;
    gain_p_next         = gain_p;
    gain_p1_next        = gain_p1;
    gain_p2_next        = gain_p2;
    pending_mode_next   = pending_mode;
    held_load           = 1'b0;
    status              = ST_BUSY;
    mode_req            = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (in_data.rx_byte == preamble) begin
          phase_next         = PH_LEN;
          byte_position_next = 3'd1;
          running_xor_next   = in_data.rx_byte;
        end else begin
          status = ST_BAD_PRE;
        end
      end
      PH_LEN: begin
        if (in_data.rx_byte == LENGTH_BYTE) begin
          phase_next         = PH_TYPE;
          byte_position_next = 3'd2;
          running_xor_next   = running_xor ^ in_data.rx_byte;
        end else begin
          status = ST_BAD_LEN;
        end
      end
      PH_TYPE: begin
        if (in_data.rx_byte <= TYPE_MAX) begin
          phase_next         = PH_PAYLOAD;
          byte_position_next = 3'd3;
          running_xor_next   = running_xor ^ in_data.rx_byte;
        end else begin
          status = ST_BAD_TYPE;
        end
      end
      PH_PAYLOAD: begin
        running_xor_next = running_xor ^ in_data.rx_byte;
        if (byte_position >= 3'd6) begin
          phase_next         = PH_CHECK;
          byte_position_next = 3'd7;
        end else begin
          phase_next         = PH_PAYLOAD;
          byte_position_next = byte_position + 3'd1;
        end
      end
      PH_CHECK: begin
        if (in_data.rx_byte == running_xor) begin
          status    = ST_OK;
          held_load = 1'b1;
          if (frame_type <= TYPE_LAST_MODE) begin
            pending_mode_next = frame_type[3:0];
            mode_req          = 1'b1;
          end else begin
            case (frame_type)
              TYPE_P_UP:    if (p_ok)   gain_p_next  = gain_up(gain_p);
              TYPE_P_DOWN:  if (p_ok)   gain_p_next  = gain_down(gain_p);
              TYPE_P1_UP:   if (all_ok) gain_p1_next = gain_up(gain_p1);
              TYPE_P1_DOWN: if (all_ok) gain_p1_next = gain_down(gain_p1);
              TYPE_P2_UP:   if (all_ok) gain_p2_next = gain_up(gain_p2);
              TYPE_P2_DOWN: if (all_ok) gain_p2_next = gain_down(gain_p2);
              default: ;
            endcase
          end
        end else begin
          status = ST_BAD_SUM;
        end
      end
      default: ;
    endcase
  end

  // Present the gains as 16-bit fields: zero-extend or keep the low bits.
  for (genvar i = 0; i < 16; i++) begin : g_gain_out
    if (i < GAIN_BITS) begin : g_bit
      assign gain_p_wide[i]  = gain_p_next[i];
      assign gain_p1_wide[i] = gain_p1_next[i];
      assign gain_p2_wide[i] = gain_p2_next[i];
    end else begin : g_zero
      assign gain_p_wide[i]  = 1'b0;
      assign gain_p1_wide[i] = 1'b0;
      assign gain_p2_wide[i] = 1'b0;
    end
  end

  // Result of this step, built from the updated state.
  always_comb begin
    result.status             = status;
    result.mode_request_valid = mode_req;
    result.requested_mode     = pending_mode_next;
    result.roll_cmd           = held_load ? payload[0] : held[0];
    result.pitch_cmd          = held_load ? payload[1] : held[1];
    result.yaw_cmd            = held_load ? payload[2] : held[2];
    result.lift_cmd           = held_load ? payload[3] : held[3];
    result.gain_p_out         = gain_p_wide;
    result.gain_p1_out        = gain_p1_wide;
    result.gain_p2_out        = gain_p2_wide;
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble       <= PREAMBLE_RESET;
      phase          <= PH_HUNT;
      byte_position  <= 3'd0;
      running_xor    <= 8'd0;
      gain_p         <= '0;
      gain_p1        <= '0;
      gain_p2        <= '0;
      pending_mode   <= 4'd0;
      for (int i = 0; i < 4; i++) held[i] <= 8'd0;
    end else begin
      if (cfg_we) begin
        preamble <= cfg_wdata;
      end
      if (accept) begin
        phase          <= phase_next;
        byte_position  <= byte_position_next;
        running_xor    <= running_xor_next;
        gain_p         <= gain_p_next;
        gain_p1        <= gain_p1_next;
        gain_p2        <= gain_p2_next;
        pending_mode   <= pending_mode_next;
        if (held_load) begin
          held[0] <= payload[0];
          held[1] <= payload[1];
          held[2] <= payload[2];
          held[3] <= payload[3];
        end
      end
    end
  end

  // Frame store: type byte and the four setpoint bytes.
  always_ff @(posedge clk) begin
    if (accept && phase == PH_TYPE) begin
      frame_type <= in_data.rx_byte;
    end
    if (accept && phase == PH_PAYLOAD) begin
      payload[payload_index] <= in_data.rx_byte;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_data <= skid_valid ? skid : result;
    end else if (accept) begin
      skid <= result;
    end
  end

endmodule
